[rtl/cad_pkg.sv]
// Shared types and constants for the collinear axis detector.
// Depends on nothing; every other file of the block refers to it by scoped names.
package cad_pkg;

  localparam int VEC_W     = 18;  // signed Q6.12 vector component
  localparam int THR_W     = 20;  // threshold register width
  localparam int AXIS_W    = 16;  // signed Q1.15 axis component
  localparam int LEN_W     = 36;  // sum of three squared components
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAG_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAR_THR = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 20'd17;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  // One classified vector on its way from the front end to the back end.
  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
    logic last;
    logic big;   // squared length is above the magnitude threshold
  } cad_item_t;

endpackage

[rtl/cad_in_if.sv]
// Input channel of the collinear axis detector: one magnetization vector per transfer.
// Depends on cad_pkg.
interface cad_in_if;
  logic          valid;
  logic          ready;
  cad_pkg::vec_t mag_x;
  cad_pkg::vec_t mag_y;
  cad_pkg::vec_t mag_z;
  logic          last_atom;

  modport source (output valid, output mag_x, output mag_y, output mag_z,
                  output last_atom, input ready);
  modport sink   (input valid, input mag_x, input mag_y, input mag_z,
                  input last_atom, output ready);
endinterface

[rtl/cad_out_if.sv]
// Result channel of the collinear axis detector: collinear flag and unit axis.
// Depends on cad_pkg.
interface cad_out_if;
  logic           valid;
  logic           ready;
  logic           collinear;
  cad_pkg::axis_t axis_x;
  cad_pkg::axis_t axis_y;
  cad_pkg::axis_t axis_z;

  modport source (output valid, output collinear, output axis_x, output axis_y,
                  output axis_z, input ready);
  modport sink   (input valid, input collinear, input axis_x, input axis_y,
                  input axis_z, output ready);
endinterface

[rtl/cad_front.sv]
// Front end: takes vectors, forms the squared length with its own multiplier and
// tags each vector against the magnitude threshold. Depends on cad_pkg and cad_in_if.
module cad_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cad_pkg::THR_W-1:0]  mag_thr,
  cad_in_if.sink                     in_ch,
  output logic                       push_valid,
  input  logic                       push_ready,
  output cad_pkg::cad_item_t         push_item
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ_X = 3'd1;
  localparam logic [2:0] F_SQ_Y = 3'd2;
  localparam logic [2:0] F_SQ_Z = 3'd3;
  localparam logic [2:0] F_SUM  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  localparam int SQ_W = cad_pkg::LEN_W - 1;

  logic [2:0]                 phase_r, phase_nxt;
  cad_pkg::vec_t              x_r, y_r, z_r;
  logic                       last_r;
  logic [SQ_W-1:0]            prod_r;
  logic [cad_pkg::LEN_W-1:0]  acc_r;
  cad_pkg::vec_t              sq_op;
  logic signed [cad_pkg::LEN_W-1:0] sq_full;
  logic                       take;

  assign push_valid  = (phase_r == F_PUSH);
  assign in_ch.ready = (phase_r == F_IDLE) || (push_valid && push_ready);
  assign take        = in_ch.valid && in_ch.ready;

  assign push_item.x    = x_r;
  assign push_item.y    = y_r;
  assign push_item.z    = z_r;
  assign push_item.last = last_r;
  assign push_item.big  =
    acc_r > {{(cad_pkg::LEN_W - cad_pkg::THR_W){1'b0}}, mag_thr};

  always_comb begin
    case (phase_r)
      F_SQ_X:  sq_op = x_r;
      F_SQ_Y:  sq_op = y_r;
      default: sq_op = z_r;
    endcase
    sq_full = sq_op * sq_op;
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      F_IDLE: begin
        if (take) phase_nxt = F_SQ_X;
      end
      F_SQ_X:  phase_nxt = F_SQ_Y;
      F_SQ_Y:  phase_nxt = F_SQ_Z;
      F_SQ_Z:  phase_nxt = F_SUM;
      F_SUM:   phase_nxt = F_PUSH;
      F_PUSH: begin
        if (push_ready) phase_nxt = take ? F_SQ_X : F_IDLE;
      end
      default: phase_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= F_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sq_full[SQ_W-1:0];
    if (take) begin
      x_r    <= in_ch.mag_x;
      y_r    <= in_ch.mag_y;
      z_r    <= in_ch.mag_z;
      last_r <= in_ch.last_atom;
      acc_r  <= '0;
    end else if (phase_r inside {F_SQ_Y, F_SQ_Z, F_SUM}) begin
      acc_r <= acc_r + {1'b0, prod_r};
    end
  end

endmodule

[rtl/cad_queue.sv]
// Short first-in first-out queue of classified vectors between front and back end.
// Depends on cad_pkg; DEPTH must be two or more.
module cad_queue #(
  parameter int DEPTH = cad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  cad_pkg::cad_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cad_pkg::cad_item_t pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  cad_pkg::cad_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

[rtl/cad_back.sv]
// Back end: holds the reference axis, runs the cross-product test and the final
// normalization on one shared multiplier, and owns the result register. Depends on cad_pkg.
module cad_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cad_pkg::THR_W-1:0] par_thr,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  cad_pkg::cad_item_t        pop_item,
  cad_out_if.source                 out_ch
);

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_CR_A   = 4'd1;
  localparam logic [3:0] B_CR_B   = 4'd2;
  localparam logic [3:0] B_CR_SUB = 4'd3;
  localparam logic [3:0] B_CR_SQ  = 4'd4;
  localparam logic [3:0] B_CR_ACC = 4'd5;
  localparam logic [3:0] B_CR_CMP = 4'd6;
  localparam logic [3:0] B_FIN    = 4'd7;
  localparam logic [3:0] B_NS_SQ  = 4'd8;
  localparam logic [3:0] B_NS_ACC = 4'd9;
  localparam logic [3:0] B_NR_K2  = 4'd10;
  localparam logic [3:0] B_NR_LO  = 4'd11;
  localparam logic [3:0] B_NR_HI  = 4'd12;
  localparam logic [3:0] B_NR_CMP = 4'd13;
  localparam logic [3:0] B_EMIT   = 4'd14;

  localparam logic [1:0] C_X = 2'd0;
  localparam logic [1:0] C_Y = 2'd1;
  localparam logic [1:0] C_Z = 2'd2;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 23;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int XP_W    = 36;  // one cross-product term
  localparam int DIFF_W  = 37;
  localparam int MAG_W   = 22;  // a difference at or above 2^22 fails any threshold
  localparam int ACC_W   = 46;
  localparam int TCMP_W  = 44;
  localparam int MSQ_W   = 35;
  localparam int K2_W    = 32;
  localparam int S_HALF  = 18;
  localparam int LO_W    = K2_W + S_HALF;
  localparam int CMP_W   = 69;
  localparam int N_W     = cad_pkg::AXIS_W;
  localparam logic [3:0] BPOS_TOP = 4'd15;
  localparam cad_pkg::axis_t AXIS_MAX = 16'sh7FFF;

  logic [3:0]  phase_r, phase_nxt;
  logic        captured_r, captured_nxt;
  logic        parallel_r, parallel_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [1:0]  comp_r;
  logic [3:0]  bpos_r;
  cad_pkg::vec_t bx_r, by_r, bz_r, ax_r, ay_r, az_r;
  logic        last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [XP_W-1:0]   t_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     ovf_r;
  logic [ACC_W-1:0]         acc_r;
  logic [cad_pkg::LEN_W-1:0] s_r;
  logic [MSQ_W-1:0]         msq_x_r, msq_y_r, msq_z_r;
  logic [K2_W-1:0]          k2_r;
  logic [LO_W-1:0]          lo_r;
  logic [N_W-1:0]           n_r;
  cad_pkg::axis_t           res_x_r, res_y_r, res_z_r;
  logic                     coll_r;
  logic                     out_coll_r;
  cad_pkg::axis_t           out_x_r, out_y_r, out_z_r;

  logic        pop_fire, out_free, emit_fire;
  cad_pkg::vec_t cr_a1, cr_b2, cr_a2, cr_b1, a_sel;
  logic [MSQ_W-1:0]         msq_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic [N_W-1:0]            cand, k_val, n_final;
  logic [CMP_W-1:0]          lhs, rhs;
  logic                      nr_pass, nr_done, cross_fail;
  cad_pkg::axis_t            res_val;

  assign pop_ready = (phase_r == B_IDLE);
  assign pop_fire  = pop_valid && pop_ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_fire = (phase_r == B_EMIT) && out_free;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.collinear = out_coll_r;
  assign out_ch.axis_x    = out_x_r;
  assign out_ch.axis_y    = out_y_r;
  assign out_ch.axis_z    = out_z_r;

  // Operand selection for the cross product and the per-component normalization.
  always_comb begin
    case (comp_r)
      C_X: begin
        cr_a1 = ay_r; cr_b2 = bz_r; cr_a2 = az_r; cr_b1 = by_r;
        a_sel = ax_r; msq_sel = msq_x_r;
      end
      C_Y: begin
        cr_a1 = az_r; cr_b2 = bx_r; cr_a2 = ax_r; cr_b1 = bz_r;
        a_sel = ay_r; msq_sel = msq_y_r;
      end
      default: begin
        cr_a1 = ax_r; cr_b2 = by_r; cr_a2 = ay_r; cr_b1 = bx_r;
        a_sel = az_r; msq_sel = msq_z_r;
      end
    endcase
  end

  always_comb begin
    diff       = DIFF_W'(t_r) - DIFF_W'(prod_r);
    diff_mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    cross_fail = ovf_r || (acc_r >= ACC_W'({par_thr, 24'b0}));
    cand       = n_r | (N_W'(1) << bpos_r);
    k_val      = {cand[N_W-2:0], 1'b0} - N_W'(1);
    lhs        = CMP_W'({prod_r[LO_W-1:0], {S_HALF{1'b0}}}) + CMP_W'(lo_r);
    rhs        = CMP_W'({msq_sel, 32'b0});
    nr_pass    = (lhs <= rhs);
    n_final    = nr_pass ? cand : n_r;
    // Once the top candidate passes, no larger quotient can, so the search ends.
    nr_done    = (bpos_r == '0) || (nr_pass && (bpos_r == BPOS_TOP));
    if (a_sel[cad_pkg::VEC_W-1]) res_val = cad_pkg::axis_t'(~n_final + 1'b1);
    else if (n_final[N_W-1])     res_val = AXIS_MAX;
    else                         res_val = cad_pkg::axis_t'(n_final);
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (phase_r)
      B_CR_A: begin
        mul_a = MUL_A_W'(cr_a1);
        mul_b = MUL_B_W'(cr_b2);
      end
      B_CR_B: begin
        mul_a = MUL_A_W'(cr_a2);
        mul_b = MUL_B_W'(cr_b1);
      end
      B_CR_SQ: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(mag_r);
      end
      B_NS_SQ: begin
        mul_a = MUL_A_W'(a_sel);
        mul_b = MUL_B_W'(a_sel);
      end
      B_NR_K2: begin
        mul_a = MUL_A_W'(k_val);
        mul_b = MUL_B_W'(k_val);
      end
      B_NR_LO: begin
        mul_a = MUL_A_W'(prod_r[K2_W-1:0]);
        mul_b = MUL_B_W'(s_r[S_HALF-1:0]);
      end
      B_NR_HI: begin
        mul_a = MUL_A_W'(k2_r);
        mul_b = MUL_B_W'(s_r[cad_pkg::LEN_W-1:S_HALF]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    captured_nxt  = captured_r;
    parallel_nxt  = parallel_r;
    out_valid_nxt = emit_fire ? 1'b1 : (out_valid_r && !out_ch.ready);
    case (phase_r)
      B_IDLE: begin
        if (pop_fire) begin
          if (!captured_r) begin
            if (pop_item.big) begin
              captured_nxt = 1'b1;
              parallel_nxt = 1'b1;
            end
            phase_nxt = B_FIN;
          end else begin
            phase_nxt = B_CR_A;
          end
        end
      end
      B_CR_A:   phase_nxt = B_CR_B;
      B_CR_B:   phase_nxt = B_CR_SUB;
      B_CR_SUB: phase_nxt = B_CR_SQ;
      B_CR_SQ:  phase_nxt = B_CR_ACC;
      B_CR_ACC: phase_nxt = (comp_r == C_Z) ? B_CR_CMP : B_CR_A;
      B_CR_CMP: begin
        if (cross_fail) parallel_nxt = 1'b0;
        phase_nxt = B_FIN;
      end
      B_FIN: begin
        if (!last_r)                       phase_nxt = B_IDLE;
        else if (captured_r && parallel_r) phase_nxt = B_NS_SQ;
        else                               phase_nxt = B_EMIT;
      end
      B_NS_SQ:  phase_nxt = B_NS_ACC;
      B_NS_ACC: phase_nxt = (comp_r == C_Z) ? B_NR_K2 : B_NS_SQ;
      B_NR_K2:  phase_nxt = B_NR_LO;
      B_NR_LO:  phase_nxt = B_NR_HI;
      B_NR_HI:  phase_nxt = B_NR_CMP;
      B_NR_CMP: begin
        if (nr_done && (comp_r == C_Z)) phase_nxt = B_EMIT;
        else                            phase_nxt = B_NR_K2;
      end
      B_EMIT: begin
        if (out_free) begin
          captured_nxt = 1'b0;
          parallel_nxt = 1'b0;
          phase_nxt    = B_IDLE;
        end
      end
      default: phase_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= B_IDLE;
      captured_r  <= 1'b0;
      parallel_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      captured_r  <= captured_nxt;
      parallel_r  <= parallel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (phase_r)
      B_IDLE: begin
        if (pop_fire) begin
          bx_r   <= pop_item.x;
          by_r   <= pop_item.y;
          bz_r   <= pop_item.z;
          last_r <= pop_item.last;
          comp_r <= C_X;
          acc_r  <= '0;
          ovf_r  <= 1'b0;
          if (!captured_r && pop_item.big) begin
            ax_r <= pop_item.x;
            ay_r <= pop_item.y;
            az_r <= pop_item.z;
          end
        end
      end
      B_CR_B:   t_r <= prod_r[XP_W-1:0];
      B_CR_SUB: begin
        mag_r <= diff_mag[MAG_W-1:0];
        if (diff_mag[DIFF_W-1:MAG_W] != '0) ovf_r <= 1'b1;
      end
      B_CR_ACC: begin
        acc_r <= acc_r + ACC_W'(prod_r[TCMP_W-1:0]);
        if (comp_r != C_Z) comp_r <= comp_r + 1'b1;
      end
      B_FIN: begin
        comp_r  <= C_X;
        s_r     <= '0;
        coll_r  <= 1'b0;
        res_x_r <= '0;
        res_y_r <= '0;
        res_z_r <= '0;
      end
      B_NS_ACC: begin
        s_r <= s_r + cad_pkg::LEN_W'(prod_r[MSQ_W-1:0]);
        case (comp_r)
          C_X:     msq_x_r <= prod_r[MSQ_W-1:0];
          C_Y:     msq_y_r <= prod_r[MSQ_W-1:0];
          default: msq_z_r <= prod_r[MSQ_W-1:0];
        endcase
        if (comp_r == C_Z) begin
          comp_r <= C_X;
          n_r    <= '0;
          bpos_r <= BPOS_TOP;
        end else begin
          comp_r <= comp_r + 1'b1;
        end
      end
      B_NR_LO: k2_r <= prod_r[K2_W-1:0];
      B_NR_HI: lo_r <= prod_r[LO_W-1:0];
      B_NR_CMP: begin
        if (nr_done) begin
          case (comp_r)
            C_X:     res_x_r <= res_val;
            C_Y:     res_y_r <= res_val;
            default: res_z_r <= res_val;
          endcase
          n_r    <= '0;
          bpos_r <= BPOS_TOP;
          if (comp_r == C_Z) coll_r <= 1'b1;
          else               comp_r <= comp_r + 1'b1;
        end else begin
          n_r    <= n_final;
          bpos_r <= bpos_r - 1'b1;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_coll_r <= coll_r;
          out_x_r    <= res_x_r;
          out_y_r    <= res_y_r;
          out_z_r    <= res_z_r;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/collinear_axis_detector.sv]
// Top level of the collinear axis detector: configuration registers, front end,
// queue and back end. Depends on cad_pkg, cad_in_if, cad_out_if and the cad_* modules.
//
// The block reads a set of magnetization vectors (signed Q6.12), one per transfer on
// in_ch, ending with the vector whose last_atom bit is set. The first vector whose
// squared length is strictly above magnitude_threshold becomes the reference axis;
// each later vector of the set is tested against it, and the set stays collinear
// only while every squared cross product is strictly below parallel_threshold
// (both thresholds carry 24 fraction bits). Only the last vector of a set produces a
// transfer on out_ch: the collinear flag and, when it is set, the axis scaled to unit
// length in Q1.15 with round half away from zero; otherwise all three axis fields are
// zero. After that result the set state is cleared for the next set. The front end
// works on one vector at a time, taking the next as it hands the last one on, and
// forms its squared length on a small multiplier of its own. The back end does all
// other arithmetic on one shared 33 by 23 bit multiplier: a vector seen before the
// axis is captured needs no product, every vector after it needs nine products in
// sequence for the cross-product test, and a last vector that closes a collinear set
// adds the normalization, a bit-by-bit search of up to sixteen steps per component.
// A queue of QUEUE_DEPTH entries sits between the two ends, and the result register
// keeps its transfer pending while the back end already works on the next set.
// The user writes the thresholds through cfg_we, cfg_idx and cfg_wdata only while
// the block is idle; the block itself does not enforce this. Both reset to 17.
module collinear_axis_detector #(
  parameter int QUEUE_DEPTH = cad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cad_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cad_pkg::THR_W-1:0]     cfg_wdata,
  cad_in_if.sink                        in_ch,
  cad_out_if.source                     out_ch
);

  logic [cad_pkg::THR_W-1:0] mag_thr_r, mag_thr_nxt;
  logic [cad_pkg::THR_W-1:0] par_thr_r, par_thr_nxt;

  logic               fq_valid, fq_ready;
  cad_pkg::cad_item_t fq_item;
  logic               qb_valid, qb_ready;
  cad_pkg::cad_item_t qb_item;

  // Register writes; an index outside the register list changes nothing.
  always_comb begin
    mag_thr_nxt = mag_thr_r;
    par_thr_nxt = par_thr_r;
    if (cfg_we) begin
      case (cfg_idx)
        cad_pkg::CFG_MAG_THR: mag_thr_nxt = cfg_wdata;
        cad_pkg::CFG_PAR_THR: par_thr_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_thr_r <= cad_pkg::THR_RESET;
      par_thr_r <= cad_pkg::THR_RESET;
    end else begin
      mag_thr_r <= mag_thr_nxt;
      par_thr_r <= par_thr_nxt;
    end
  end

  // The front end tags each vector with its magnitude test before it is queued.
  cad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mag_thr    (mag_thr_r),
    .in_ch      (in_ch),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item)
  );

  cad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // The back end owns the set state and the result register.
  cad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .par_thr   (par_thr_r),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_item  (qb_item),
    .out_ch    (out_ch)
  );

endmodule

[rtl/cad_checker.sv]
// Port-level checks on the result channel of the collinear axis detector, bound
// to the top level. Depends on cad_pkg and collinear_axis_detector.
module cad_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input logic           out_collinear,
  input cad_pkg::axis_t out_axis_x,
  input cad_pkg::axis_t out_axis_y,
  input cad_pkg::axis_t out_axis_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_collinear) && $stable(out_axis_x) &&
                                $stable(out_axis_y) && $stable(out_axis_z))
    else $error("stalled result changed");

  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_collinear |->
      out_axis_x == '0 && out_axis_y == '0 && out_axis_z == '0)
    else $error("axis not zero on a non-collinear result");

  a_unit_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_collinear |->
      out_axis_x != '0 || out_axis_y != '0 || out_axis_z != '0)
    else $error("collinear result with a zero axis");

endmodule

bind collinear_axis_detector cad_checker u_cad_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_collinear (out_ch.collinear),
  .out_axis_x    (out_ch.axis_x),
  .out_axis_y    (out_ch.axis_y),
  .out_axis_z    (out_ch.axis_z)
);
